/* sv/tsf_pkg.sv */
// tsf_pkg: shared constants and types for the triangle span fill unit
// no dependencies

package tsf_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 16;
  // coordinate differences need one extra bit
  localparam int unsigned DiffBits  = CoordBits + 1;
  // dividend width: difference scaled by the fraction
  localparam int unsigned NumBits   = DiffBits + FracBits;
  // slope and accumulator width
  localparam int unsigned AccBits   = NumBits + 1;
  localparam int unsigned SpanBits  = 17;
  localparam int unsigned ColorBits = 24;
  localparam int unsigned InBits    = 6 * 16 + ColorBits;
  localparam int unsigned InBytes   = (InBits + 7) / 8;
  localparam int unsigned OutBits   = 16 + 2 * SpanBits + ColorBits;
  localparam int unsigned OutBytes  = (OutBits + 7) / 8;
  localparam int unsigned CntBits   = $clog2(NumBits + 1);

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // item passed from the front end to the back end
  typedef struct packed {
    logic                        op;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic [ColorBits-1:0]        color;
  } cmd_t;

  // divider request and response
  typedef struct packed {
    logic                       start;
    logic signed [DiffBits-1:0] dx;
    logic signed [DiffBits-1:0] dy;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [AccBits-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/tsf_front.sv */
// tsf_front: accepts input transfers and queues them as commands
// depends on tsf_pkg

module tsf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tsf_pkg::InBytes*8-1:0]      s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output tsf_pkg::cmd_t                      cmd_o
);

  // two-entry queue
  tsf_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  tsf_pkg::cmd_t in_cmd;

  // unpack the input word into fields
  always_comb begin
    in_cmd.op    = s_axis_tuser;
    in_cmd.ax    = s_axis_tdata[15:0];
    in_cmd.ay    = s_axis_tdata[31:16];
    in_cmd.bx    = s_axis_tdata[47:32];
    in_cmd.by    = s_axis_tdata[63:48];
    in_cmd.cx    = s_axis_tdata[79:64];
    in_cmd.cy    = s_axis_tdata[95:80];
    in_cmd.color = s_axis_tdata[119:96];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  ap_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !s_axis_tready) else $error("queue accepts while full");
  ap_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  ap_valid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o == (cnt_q != 2'd0)) else $error("valid disagrees with count");

endmodule

/* sv/tsf_div.sv */
// tsf_div: restoring divider, one quotient bit per cycle, for slopes
// depends on tsf_pkg

module tsf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsf_pkg::div_req_t req_i,
  output tsf_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NB = tsf_pkg::NumBits;
  localparam int unsigned DB = tsf_pkg::DiffBits;

  logic                    busy_q, done_q;
  logic [tsf_pkg::CntBits-1:0] cnt_q;
  logic [NB-1:0]           num_q;   // dividend magnitude, shifted out msb first
  logic [NB-1:0]           quo_q;
  logic [DB:0]             rem_q;
  logic [DB:0]             den_q;
  logic                    neg_q;
  logic [DB:0]             rem_sh, rem_sub;
  logic [DB-1:0]           dx_mag;
  logic signed [DB+1:0]    den_full;

  // denominator dy+1 clamped to at least 1
  always_comb begin
    den_full = {req_i.dy[DB-1], req_i.dy} + (DB+2)'(1);
    dx_mag   = req_i.dx[DB-1] ? DB'(-req_i.dx) : req_i.dx;
    rem_sh   = {rem_q[DB-1:0], num_q[NB-1]};
    rem_sub  = rem_sh - den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= tsf_pkg::CntBits'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tsf_pkg::CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= {dx_mag, tsf_pkg::FracBits'(0)};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= (den_full < (DB+2)'(1)) ? (DB+1)'(1) : den_full[DB:0];
      neg_q <= req_i.dx[DB-1];
    end else if (busy_q) begin
      num_q <= {num_q[NB-2:0], 1'b0};
      if (!rem_sub[DB]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  ap_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  ap_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider count lost");

endmodule

/* sv/tsf_back.sv */
// tsf_back: sets up triangles and steps edges to produce spans
// depends on tsf_pkg and tsf_div

module tsf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  tsf_pkg::cmd_t                 cmd_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tsf_pkg::OutBytes*8-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned CB = tsf_pkg::CoordBits;
  localparam int unsigned AB = tsf_pkg::AccBits;
  localparam int unsigned FB = tsf_pkg::FracBits;
  localparam int unsigned DB = tsf_pkg::DiffBits;
  localparam int unsigned SB = tsf_pkg::SpanBits;

  // control states
  localparam logic [2:0] StRun  = 3'd0;
  localparam logic [2:0] StDiv0 = 3'd1;
  localparam logic [2:0] StDiv1 = 3'd2;
  localparam logic [2:0] StDiv2 = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhUpper = 2'd1;
  localparam logic [1:0] PhLower = 2'd2;

  logic [2:0] st_q;
  logic [1:0] phase_q;
  logic signed [CB-1:0] row_q, mid_row_q, bot_row_q, mid_x_q, top_x_q, top_row_q;
  logic signed [CB-1:0] bot_x_q;
  logic signed [AB-1:0] short_q, long_q, s_tm_q, s_tb_q, s_mb_q;
  logic signed [AB-1:0] long_mid_q;
  logic [tsf_pkg::ColorBits-1:0] color_q;

  // output register
  logic                 ov_q, o_valid_q, o_last_q;
  logic signed [CB-1:0] o_row_q;
  logic signed [SB-1:0] o_left_q, o_right_q;
  logic [tsf_pkg::ColorBits-1:0] o_color_q;

  tsf_pkg::div_req_t div_req;
  tsf_pkg::div_rsp_t div_rsp;

  tsf_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // sort vertices by y with stable ties
  logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, t0x, t0y, t1x, t1y, t2x, t2y;
  always_comb begin
    t0x = cmd_i.ax; t0y = cmd_i.ay; t1x = cmd_i.bx; t1y = cmd_i.by;
    t2x = cmd_i.cx; t2y = cmd_i.cy;
    x1 = t0x; y1 = t0y; x2 = t1x; y2 = t1y; x3 = t2x; y3 = t2y;
    if (t0y > t1y) begin
      x1 = t1x; y1 = t1y; x2 = t0x; y2 = t0y;
    end
    if (y2 > y3) begin
      t0x = x2; t0y = y2; x2 = x3; y2 = y3; x3 = t0x; y3 = t0y;
    end
    if (y1 > y2) begin
      t0x = x1; t0y = y1; x1 = x2; y1 = y2; x2 = t0x; y2 = t0y;
    end
  end

  // edge x truncated toward zero
  function automatic logic signed [SB-1:0] trunc_x(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] a;
    a = v[AB-1] ? (v + AB'((1 << FB) - 1)) : v;
    return SB'(a >>> FB);
  endfunction

  logic signed [SB-1:0] ea, eb;
  logic out_free, tick_go, load_go;
  logic signed [DB-1:0] mul_dy;
  logic signed [AB+DB-1:0] mul_p;

  assign ea       = trunc_x(short_q);
  assign eb       = trunc_x(long_q);
  assign out_free = !ov_q || m_axis_tready;
  assign cmd_ready_o = (st_q == StRun) &&
                       ((cmd_i.op == tsf_pkg::OpLoad) || out_free);
  assign load_go  = cmd_valid_i && cmd_ready_o && (cmd_i.op == tsf_pkg::OpLoad);
  assign tick_go  = cmd_valid_i && cmd_ready_o && (cmd_i.op == tsf_pkg::OpTick);
  assign mul_dy   = DB'(mid_row_q) - DB'(top_row_q);
  assign mul_p    = s_tb_q * mul_dy;

  // divider requests per setup step
  always_comb begin
    div_req = '0;
    if (load_go) begin
      div_req.start = 1'b1;
      div_req.dx    = DB'(x2) - DB'(x1);
      div_req.dy    = DB'(y2) - DB'(y1);
    end else if (div_rsp.done && st_q == StDiv0) begin
      div_req.start = 1'b1;
      div_req.dx    = DB'(bot_x_q) - DB'(top_x_q);
      div_req.dy    = DB'(bot_row_q) - DB'(top_row_q);
    end else if (div_rsp.done && st_q == StDiv1) begin
      div_req.start = 1'b1;
      div_req.dx    = DB'(bot_x_q) - DB'(mid_x_q);
      div_req.dy    = DB'(bot_row_q) - DB'(mid_row_q);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StRun;
      phase_q <= PhIdle;
      ov_q    <= 1'b0;
    end else begin
      if (m_axis_tready) ov_q <= 1'b0;
      case (st_q)
        StRun: begin
          if (load_go) begin
            st_q    <= StDiv0;
            phase_q <= PhUpper;
          end else if (tick_go) begin
            ov_q <= 1'b1;
            if (phase_q == PhUpper && row_q == mid_row_q) phase_q <= PhLower;
            else if (phase_q == PhLower && row_q == bot_row_q) phase_q <= PhIdle;
          end
        end
        StDiv0: if (div_rsp.done) st_q <= StDiv1;
        StDiv1: if (div_rsp.done) st_q <= StDiv2;
        StDiv2: if (div_rsp.done) st_q <= StMul;
        StMul:  st_q <= StRun;
        default: st_q <= StRun;
      endcase
    end
  end

  // triangle state and output payload
  always_ff @(posedge clk_i) begin
    if (load_go) begin
      row_q <= y1; mid_row_q <= y2; bot_row_q <= y3;
      mid_x_q <= x2; top_x_q <= x1; top_row_q <= y1; bot_x_q <= x3;
      short_q <= AB'(x1) <<< FB;
      long_q  <= AB'(x1) <<< FB;
      color_q <= cmd_i.color;
    end
    if (div_rsp.done) begin
      if (st_q == StDiv0) s_tm_q <= div_rsp.quot;
      if (st_q == StDiv1) s_tb_q <= div_rsp.quot;
      if (st_q == StDiv2) s_mb_q <= div_rsp.quot;
    end
    if (st_q == StMul) long_mid_q <= (AB'(top_x_q) <<< FB) + AB'(mul_p);
    if (tick_go) begin
      o_valid_q <= (phase_q != PhIdle);
      o_last_q  <= 1'b0;
      o_row_q   <= '0;
      o_left_q  <= '0;
      o_right_q <= '0;
      o_color_q <= '0;
      if (phase_q != PhIdle) begin
        o_row_q   <= row_q;
        o_left_q  <= (ea < eb) ? ea : eb;
        o_right_q <= (ea < eb) ? eb : ea;
        o_color_q <= color_q;
        o_last_q  <= (phase_q == PhLower) && (row_q == bot_row_q);
      end
      if (phase_q == PhUpper) begin
        if (row_q == mid_row_q) begin
          short_q <= AB'(mid_x_q) <<< FB;
          long_q  <= long_mid_q;
        end else begin
          row_q   <= row_q + CB'(1);
          short_q <= short_q + s_tm_q;
          long_q  <= long_q + s_tb_q;
        end
      end else if (phase_q == PhLower && row_q != bot_row_q) begin
        row_q   <= row_q + CB'(1);
        short_q <= short_q + s_mb_q;
        long_q  <= long_q + s_tb_q;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_valid_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {(tsf_pkg::OutBytes*8 - tsf_pkg::OutBits)'(0),
                          o_color_q, o_right_q, o_left_q, o_row_q};

  ap_setup_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StRun |-> !cmd_ready_o) else $error("command taken during setup");
  ap_load_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_go |=> st_q == StDiv0) else $error("load did not start setup");
  ap_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && o_last_q |-> o_valid_q) else $error("last on invalid span");
  ap_tick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> ov_q) else $error("tick without result");

endmodule

/* sv/triangle_scanline_span_fill_unit.sv */
// triangle_scanline_span_fill_unit: top level of the triangle span fill unit
// depends on tsf_pkg, tsf_front, tsf_back, tsf_div
//
// usage: the slave stream carries commands; tuser is the operation: 0 loads
// a triangle (three vertices and a color in tdata), 1 is a tick that asks
// for a span. a load gives no result; each tick gives one master transfer:
// tuser is the span valid flag (0 for a tick while idle), tlast marks the
// final span. a front queue of two entries takes commands while the back
// end works.
// a load occupies the back end while the bit-serial slope divider runs once
// per edge; ticks are then handled one per cycle while the output is free.
// a span appears in the cycle after its tick enters the back end and holds in
// the output register while tready is low; the back end then stalls ticks and
// the front queue fills, dropping tready on the slave side.
// reset clears the queue, the output valid flag and the phase to idle.

module triangle_scanline_span_fill_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color
  input  logic [tsf_pkg::InBytes*8-1:0]       s_axis_tdata,
  // operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // span_row, span_left, span_right, span_color
  output logic [tsf_pkg::OutBytes*8-1:0]      m_axis_tdata,
  // span_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  logic          cmd_valid, cmd_ready;
  tsf_pkg::cmd_t cmd;

  tsf_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tsf_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .m_axis_tlast
  );

endmodule

/* tb/tsf_span_checker.sv */
// tsf_span_checker: watches both stream channels of the span fill unit,
// predicts every span from the accepted commands and compares them in order
// depends on tsf_pkg
`timescale 1ns / 100ps

module tsf_span_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [tsf_pkg::InBytes*8-1:0]      s_axis_tdata,
  input  logic                               s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [tsf_pkg::OutBytes*8-1:0]     m_axis_tdata,
  input  logic                               m_axis_tuser,
  input  logic                               m_axis_tlast,
  output int                                 fail_count_o,
  output int                                 spans_pending_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhUpper,
    PhLower
  } walk_phase_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] row;
    logic [16:0] left;
    logic [16:0] right;
    logic [23:0] color;
    logic        last;
  } span_t;

  localparam longint FxOne = longint'(1) << tsf_pkg::FracBits;

  // predictor state
  walk_phase_e walk_phase;
  int          row_now, mid_row, bottom_row, mid_x, top_x, top_row;
  longint      short_x, long_x, slope_tm, slope_tb, slope_mb;
  logic [23:0] tri_color;
  span_t       span_q[$];

  assign spans_pending_o = span_q.size();

  // dx / (dy + 1) in fixed point, truncated toward zero
  function automatic longint edge_slope(int dx, int dy);
    longint den;
    den = longint'(dy) + 1;
    if (den < 1) begin
      den = 1;
    end
    return (longint'(dx) * FxOne) / den;
  endfunction

  // load a triangle: sort by y (stable), set slopes and accumulators
  task automatic load_triangle(input logic [tsf_pkg::InBytes*8-1:0] d);
    int x1, y1, x2, y2, x3, y3, t;
    x1 = int'($signed(d[15:0]));
    y1 = int'($signed(d[31:16]));
    x2 = int'($signed(d[47:32]));
    y2 = int'($signed(d[63:48]));
    x3 = int'($signed(d[79:64]));
    y3 = int'($signed(d[95:80]));
    if (y1 > y2) begin
      t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t;
    end
    if (y2 > y3) begin
      t = y2; y2 = y3; y3 = t; t = x2; x2 = x3; x3 = t;
    end
    if (y1 > y2) begin
      t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t;
    end
    slope_tm   = edge_slope(x2 - x1, y2 - y1);
    slope_tb   = edge_slope(x3 - x1, y3 - y1);
    slope_mb   = edge_slope(x3 - x2, y3 - y2);
    short_x    = longint'(x1) * FxOne;
    long_x     = short_x;
    row_now    = y1;
    mid_row    = y2;
    bottom_row = y3;
    mid_x      = x2;
    top_x      = x1;
    top_row    = y1;
    tri_color  = d[119:96];
    walk_phase = PhUpper;
  endtask

  // one tick: emit the current span and step the edges
  task automatic tick_span();
    span_t  s;
    longint a, b;
    s = '0;
    if (walk_phase != PhIdle) begin
      a = short_x / FxOne;
      b = long_x / FxOne;
      s.valid = 1'b1;
      s.row   = row_now[15:0];
      s.left  = (a < b) ? a[16:0] : b[16:0];
      s.right = (a < b) ? b[16:0] : a[16:0];
      s.color = tri_color;
      s.last  = (walk_phase == PhLower) && (row_now == bottom_row);
      if (walk_phase == PhUpper) begin
        if (row_now == mid_row) begin
          walk_phase = PhLower;
          short_x    = longint'(mid_x) * FxOne;
          long_x     = longint'(top_x) * FxOne + slope_tb * longint'(mid_row - top_row);
        end else begin
          row_now++;
          short_x += slope_tm;
          long_x  += slope_tb;
        end
      end else if (row_now == bottom_row) begin
        walk_phase = PhIdle;
      end else begin
        row_now++;
        short_x += slope_mb;
        long_x  += slope_tb;
      end
    end
    span_q.push_back(s);
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_span();
    span_t got, want;
    got.valid = m_axis_tuser;
    got.row   = m_axis_tdata[15:0];
    got.left  = m_axis_tdata[32:16];
    got.right = m_axis_tdata[49:33];
    got.color = m_axis_tdata[73:50];
    got.last  = m_axis_tlast;
    if (span_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("unexpected span transfer: %p", got);
      end
    end else begin
      want = span_q.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("span mismatch at %0t: expected %p actual %p", $realtime, want, got);
        end
      end
    end
  endtask

  initial fail_count_o = 0;

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_phase = PhIdle;
      row_now = 0; mid_row = 0; bottom_row = 0; mid_x = 0; top_x = 0; top_row = 0;
      short_x = 0; long_x = 0; slope_tm = 0; slope_tb = 0; slope_mb = 0;
      tri_color = '0;
      span_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_span();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == tsf_pkg::OpLoad) begin
          load_triangle(s_axis_tdata);
        end else begin
          tick_span();
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for the triangle span fill unit
// depends on tsf_pkg, triangle_scanline_span_fill_unit, tsf_span_checker
`timescale 1ns / 100ps

module tb;

  localparam int CycleLimit = 400000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color
  logic [tsf_pkg::InBytes*8-1:0]     s_axis_tdata = '0;
  // operation
  logic                              s_axis_tuser = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // span_row, span_left, span_right, span_color
  logic [tsf_pkg::OutBytes*8-1:0]    m_axis_tdata;
  // span_valid
  logic                              m_axis_tuser;
  logic                              m_axis_tlast;

  int fail_count, spans_pending, cycle_count;
  int send_idle_pct, recv_idle_pct, items_sent;

  triangle_scanline_span_fill_unit uut (.*);

  tsf_span_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .spans_pending_o(spans_pending)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_cmd(input logic op, input int ax, input int ay, input int bx,
                          input int by, input int cx, input int cy,
                          input logic [23:0] color);
    logic [tsf_pkg::InBytes*8-1:0] d;
    d = '0;
    d[15:0]   = ax[15:0];
    d[31:16]  = ay[15:0];
    d[47:32]  = bx[15:0];
    d[63:48]  = by[15:0];
    d[79:64]  = cx[15:0];
    d[95:80]  = cy[15:0];
    d[119:96] = color;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_cmd(tsf_pkg::OpTick, $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom());
    end
  endtask

  function automatic int rand_coord();
    return int'($signed(16'($urandom())));
  endfunction

  // random triangle over a short row range, mostly walked fully, else cut short or given extra ticks
  task automatic random_triangle();
    int base, ya, yb, yc, lo, hi, n;
    base = $urandom_range(0, 65535 - 40) - 32768;
    ya = base + $urandom_range(0, 20);
    yb = base + $urandom_range(0, 20);
    yc = base + $urandom_range(0, 20);
    send_cmd(tsf_pkg::OpLoad, rand_coord(), ya, rand_coord(), yb, rand_coord(), yc,
             $urandom());
    lo = (ya < yb) ? ((ya < yc) ? ya : yc) : ((yb < yc) ? yb : yc);
    hi = (ya > yb) ? ((ya > yc) ? ya : yc) : ((yb > yc) ? yb : yc);
    n = hi - lo + 2;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, n);
      1: n = n + $urandom_range(1, 3);
      default: ;
    endcase
    ticks(n);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick while idle, extremes, ties, flat triangle, reload mid-walk
    send_idle_pct = 14;
    recv_idle_pct = 77;
    ticks(1);
    send_cmd(tsf_pkg::OpLoad, -32768, -32768, 32767, -32766, -32768, -32764, 24'hFFFFFF);
    ticks(7);
    send_cmd(tsf_pkg::OpLoad, 32767, 32765, -32768, 32767, 100, 32767, 24'h000000);
    ticks(5);
    send_cmd(tsf_pkg::OpLoad, 5, 10, -7, 10, 3, 10, 24'h123456);
    ticks(3);
    send_cmd(tsf_pkg::OpLoad, -32768, 32767, 32767, -32768, 0, 0, 24'hA5A5A5);
    ticks(2);
    send_cmd(tsf_pkg::OpLoad, 0, 3, 9, 0, -9, 1, 24'h5A5A5A);
    ticks(2);

    // random part in three idling regimes
    while (items_sent < 1300) begin
      if (items_sent > 870) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent > 450) begin
        send_idle_pct = 77;
        recv_idle_pct = 14;
      end
      if ($urandom_range(0, 9) == 0) begin
        // full-range noise load, abandoned after a few ticks
        send_cmd(tsf_pkg::OpLoad, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), $urandom());
        ticks($urandom_range(0, 4));
      end else begin
        random_triangle();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (spans_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tsf_pkg.sv
sv/tsf_front.sv
sv/tsf_div.sv
sv/tsf_back.sv
sv/triangle_scanline_span_fill_unit.sv
tb/tsf_span_checker.sv
tb/tb.sv
